// ===== src/dfsa_pkg.sv =====
// Shared types, constants and helper functions for the deferred free slot allocator.
// No dependencies; every other file imports this package.

package dfsa_pkg;

    // pool geometry
    localparam int SLOTS     = 1024;
    localparam int FRAMES    = 3;
    localparam int WORD_BITS = 64;
    localparam int WORDS     = SLOTS / WORD_BITS;
    localparam int WORD_AW   = $clog2(WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int SLOT_W    = 10;
    localparam int CNT_W     = 11;
    localparam int FRAME_W   = 2;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef word_t [FRAMES-1:0]   pend_row_t;

    // request kinds
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EOF   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_FREE  = 2'd1,
        STAT_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_FREE,
        S_EOF,
        S_RESP
    } state_t;

    // write of one row of both maps
    typedef struct packed {
        logic               en;
        logic [WORD_AW-1:0] addr;
        word_t              free_word;
        pend_row_t          pend_row;
    } map_wr_t;

    // row read back from both maps, in the cycle after the address
    typedef struct packed {
        word_t     free_word;
        pend_row_t pend_row;
    } map_rd_t;

    // free bits of one word right after init: slots below n are free
    function automatic word_t init_word(input logic [WORD_AW-1:0] w,
                                        input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] diff;
        word_t            r;
        base = CNT_W'(w) << BIT_W;
        diff = n - base;
        if (n >= base + CNT_W'(WORD_BITS)) begin
            r = '1;
        end else if (n > base) begin
            r = (word_t'(1) << diff[BIT_W-1:0]) - word_t'(1);
        end else begin
            r = '0;
        end
        return r;
    endfunction

    // index of the lowest set bit of a word
    function automatic logic [BIT_W-1:0] lowest_bit(input word_t v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

    // index of the lowest word flagged as holding a free slot
    function automatic logic [WORD_AW-1:0] lowest_word(input logic [WORDS-1:0] v);
        logic [WORD_AW-1:0] idx;
        idx = '0;
        for (int i = WORDS - 1; i >= 0; i--) begin
            if (v[i]) idx = WORD_AW'(i);
        end
        return idx;
    endfunction

endpackage

// ===== src/deferred_free_slot_allocator.sv =====
// Allocate and free: the map is read as the word is accepted in S_IDLE, the row is checked and
// written in S_ALLOC or S_FREE and the result passes through S_RESP to the output register; no new
// word is taken until then. End of frame: S_EOF merges one map row per cycle through the single
// read port of each map memory (read, modify, write back). Reset is synchronous and active low;
// valid bits on the map rows stand in for a clearing pass. A config write reinitializes the maps the same way.
// Depends on dfsa_pkg and dfsa_maps.

module deferred_free_slot_allocator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dfsa_pkg::CNT_W-1:0]   cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dfsa_pkg::FUNC_W-1:0]  s_func,
    input  logic [dfsa_pkg::SLOT_W-1:0]  s_slot_index,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dfsa_pkg::SLOT_W-1:0]  m_granted_slot,
    output logic [dfsa_pkg::STATUS_W-1:0] m_status
);
    import dfsa_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   eff_reg, eff_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [WORD_AW-1:0] addr_reg, addr_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               nofree_reg, nofree_next;
    logic [WORDS-1:0]   avail_reg, avail_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    status_t            res_status_reg, res_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]  m_slot_reg, m_slot_next;
    status_t            m_status_reg, m_status_next;

    logic               in_acc;
    logic               cfg_acc;
    logic               out_free;
    logic               clear;
    logic [CNT_W-1:0]   clear_cnt;
    logic [WORD_AW-1:0] raddr;
    logic [WORD_AW-1:0] alloc_w;
    map_wr_t            wr;
    map_rd_t            rd;
    logic [BIT_W-1:0]   alloc_b;
    word_t              alloc_word;
    logic [BIT_W-1:0]   free_b;
    logic               pend_any;
    logic               bad_free;
    pend_row_t          pend_set;
    word_t              merged;
    pend_row_t          pend_clr;

    // handshakes; config wins over a request in the same cycle
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign in_acc    = s_valid && s_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // effective count on a config write, capped at SLOTS
    assign clear     = cfg_acc;
    assign clear_cnt = (cfg_data < CNT_W'(SLOTS)) ? cfg_data : CNT_W'(SLOTS);

    assign alloc_w = lowest_word(avail_reg);

    // map read address
    always_comb begin
        raddr = addr_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_func == FUNC_ALLOC) begin
                    raddr = alloc_w;
                end else if (s_func == FUNC_FREE) begin
                    raddr = s_slot_index[SLOT_W-1:BIT_W];
                end else begin
                    raddr = '0;
                end
            end
            S_EOF:   raddr = addr_reg + WORD_AW'(1);
            default: raddr = addr_reg;
        endcase
    end

    dfsa_maps u_maps (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (clear),
        .eff     (eff_reg),
        .raddr   (raddr),
        .wr      (wr),
        .rd      (rd)
    );

    // allocate: clear the lowest free bit of the chosen word
    assign alloc_b    = lowest_bit(rd.free_word);
    assign alloc_word = rd.free_word & ~(word_t'(1) << alloc_b);

    // free: range, already free, already pending in any frame
    assign free_b = slot_reg[BIT_W-1:0];
    always_comb begin
        pend_any = 1'b0;
        for (int f = 0; f < FRAMES; f++) begin
            pend_any = pend_any | rd.pend_row[f][free_b];
        end
        bad_free = (CNT_W'(slot_reg) >= eff_reg) || rd.free_word[free_b] || pend_any;
        pend_set = rd.pend_row;
        pend_set[frame_reg][free_b] = 1'b1;
    end

    // end of frame: merge the oldest frame's pending row into the free word
    always_comb begin
        merged   = rd.free_word | rd.pend_row[frame_reg];
        pend_clr = rd.pend_row;
        pend_clr[frame_reg] = '0;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_func == FUNC_ALLOC) begin
                        state_next = S_ALLOC;
                    end else if (s_func == FUNC_FREE) begin
                        state_next = S_FREE;
                    end else if (s_func == FUNC_EOF) begin
                        state_next = S_EOF;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_ALLOC: state_next = S_RESP;
            S_FREE:  state_next = S_RESP;
            S_EOF: begin
                if (addr_reg == WORD_AW'(WORDS - 1)) state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and map writes
    always_comb begin
        eff_next        = eff_reg;
        frame_next      = frame_reg;
        addr_next       = addr_reg;
        slot_next       = slot_reg;
        nofree_next     = nofree_reg;
        avail_next      = avail_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        wr.en           = 1'b0;
        wr.addr         = addr_reg;
        wr.free_word    = rd.free_word;
        wr.pend_row     = rd.pend_row;
        case (state_reg)
            S_IDLE: begin
                if (cfg_acc) begin
                    eff_next   = clear_cnt;
                    frame_next = '0;
                    for (int w = 0; w < WORDS; w++) begin
                        avail_next[w] = clear_cnt > (CNT_W'(w) << BIT_W);
                    end
                end else if (in_acc) begin
                    addr_next       = raddr;
                    slot_next       = s_slot_index;
                    nofree_next     = !(|avail_reg);
                    res_slot_next   = '0;
                    res_status_next = STAT_OK;
                    if (s_func == FUNC_EOF) begin
                        frame_next = (frame_reg == FRAME_W'(FRAMES - 1)) ? '0
                                                        : frame_reg + FRAME_W'(1);
                    end
                end
            end
            S_ALLOC: begin
                if (nofree_reg) begin
                    res_status_next = STAT_NO_FREE;
                end else begin
                    wr.en        = 1'b1;
                    wr.free_word = alloc_word;
                    avail_next[addr_reg] = |alloc_word;
                    res_slot_next = SLOT_W'({addr_reg, alloc_b});
                end
            end
            S_FREE: begin
                if (bad_free) begin
                    res_status_next = STAT_BAD_FREE;
                end else begin
                    wr.en       = 1'b1;
                    wr.pend_row = pend_set;
                end
            end
            S_EOF: begin
                wr.en        = 1'b1;
                wr.free_word = merged;
                wr.pend_row  = pend_clr;
                avail_next[addr_reg] = |merged;
                addr_next    = addr_reg + WORD_AW'(1);
            end
            default: ;
        endcase
    end

    // output register
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_slot_next   = m_slot_reg;
        m_status_next = m_status_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (state_reg == S_RESP && out_free) begin
            m_valid_next  = 1'b1;
            m_slot_next   = res_slot_reg;
            m_status_next = res_status_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_granted_slot = m_slot_reg;
    assign m_status       = m_status_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            eff_reg     <= CNT_W'(SLOTS);
            frame_reg   <= '0;
            avail_reg   <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            eff_reg     <= eff_next;
            frame_reg   <= frame_next;
            avail_reg   <= avail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        slot_reg       <= slot_next;
        nofree_reg     <= nofree_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        m_slot_reg     <= m_slot_next;
        m_status_reg   <= m_status_next;
    end

endmodule

// ===== src/dfsa_maps.sv =====
// Free map and pending map memories with registered read.
// Row valid bits make unwritten rows read as their init value. Depends on dfsa_pkg.

module dfsa_maps (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  logic [dfsa_pkg::CNT_W-1:0]  eff,
    input  logic [dfsa_pkg::WORD_AW-1:0] raddr,
    input  dfsa_pkg::map_wr_t           wr,
    output dfsa_pkg::map_rd_t           rd
);
    import dfsa_pkg::*;

    word_t              free_mem [WORDS];
    pend_row_t          pend_mem [WORDS];
    word_t              free_q_reg;
    pend_row_t          pend_q_reg;
    logic [WORD_AW-1:0] raddr_reg;
    logic [WORDS-1:0]   fvalid_reg;
    logic [WORDS-1:0]   pvalid_reg;

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            free_mem[wr.addr] <= wr.free_word;
            pend_mem[wr.addr] <= wr.pend_row;
        end
        free_q_reg <= free_mem[raddr];
        pend_q_reg <= pend_mem[raddr];
        raddr_reg  <= raddr;
    end

    // row valid bits, dropped on reset or reinit
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            fvalid_reg <= '0;
            pvalid_reg <= '0;
        end else if (wr.en) begin
            fvalid_reg[wr.addr] <= 1'b1;
            pvalid_reg[wr.addr] <= 1'b1;
        end
    end

    // rows never written read as the init value
    always_comb begin
        rd.free_word = fvalid_reg[raddr_reg] ? free_q_reg : init_word(raddr_reg, eff);
        rd.pend_row  = pvalid_reg[raddr_reg] ? pend_q_reg : '0;
    end

endmodule

// ===== src/dfsa_checker.sv =====
// Port-level checks for the deferred free slot allocator, bound to the top level.
// Depends on dfsa_pkg and deferred_free_slot_allocator.

module dfsa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [dfsa_pkg::SLOT_W-1:0]   m_granted_slot,
    input logic [dfsa_pkg::STATUS_W-1:0] m_status
);
    import dfsa_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted_slot) && $stable(m_status))
        else $error("result word changed while stalled");

    // failed requests never carry a slot
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_OK) |-> m_granted_slot == '0)
        else $error("error result with nonzero slot");

    // one request in flight: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while one is in flight");

    // config write and request never complete together
    a_cfg_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |-> !(s_valid && s_ready))
        else $error("config write and request in the same cycle");

endmodule

bind deferred_free_slot_allocator dfsa_checker u_dfsa_checker (.*);

// ===== test/tb_deferred_free_slot_allocator.sv =====
// Self-checking testbench for deferred_free_slot_allocator: random and directed requests,
// a bit-map predictor of the slot pool and a result scoreboard with random stalls.
// Depends on dfsa_pkg and the allocator RTL.

module tb_deferred_free_slot_allocator;
    import dfsa_pkg::*;

    // request kind the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int IDLE_PCT    = 38;
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
    } request_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted;
        status_t           status;
    } slot_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CNT_W-1:0]    cfg_data = CNT_W'(SLOTS);
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func = FUNC_ALLOC;
    logic [SLOT_W-1:0]   s_slot_index = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [SLOT_W-1:0]   m_granted_slot;
    logic [STATUS_W-1:0] m_status;

    // predicted pool state
    logic [SLOTS-1:0] free_slots;
    logic [SLOTS-1:0] pending_slots [FRAMES];
    int               frame_now;
    int               pool_size;

    request_t     request_q [$];
    slot_result_t awaited_results [$];

    int  words_queued = 0;
    int  words_taken = 0;
    int  results_seen = 0;
    int  cfg_writes = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  grants = 0;
    int  refusals = 0;
    int  bad_frees = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  steady = 1'b0;
    logic s_took = 1'b0;

    int pool_plan [7] = '{1024, 64, 2047, 130, 8, 1024, 16};

    deferred_free_slot_allocator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_slot_index   (s_slot_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_granted_slot (m_granted_slot),
        .m_status       (m_status)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // new pool size: slots below it free, pending lists empty, frame zero
    function automatic void reset_pool(input int unsigned value);
        pool_size = (value > SLOTS) ? SLOTS : int'(value);
        free_slots = '0;
        for (int i = 0; i < pool_size; i++) free_slots[i] = 1'b1;
        for (int f = 0; f < FRAMES; f++) pending_slots[f] = '0;
        frame_now = 0;
    endfunction

    // effect of one request on the pool, and the word it should return
    function automatic slot_result_t apply_request(input logic [FUNC_W-1:0] kind,
                                                   input logic [SLOT_W-1:0] slot);
        slot_result_t r;
        logic         bad;
        int           lowest;
        r.granted = '0;
        r.status = STAT_OK;
        case (kind)
            FUNC_ALLOC: begin
                lowest = -1;
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (free_slots[i]) lowest = i;
                end
                if (lowest < 0) begin
                    r.status = STAT_NO_FREE;
                end else begin
                    free_slots[lowest] = 1'b0;
                    r.granted = SLOT_W'(lowest);
                end
            end
            FUNC_FREE: begin
                bad = (int'(slot) >= pool_size) || free_slots[slot];
                for (int f = 0; f < FRAMES; f++) bad = bad | pending_slots[f][slot];
                if (bad) r.status = STAT_BAD_FREE;
                else pending_slots[frame_now][slot] = 1'b1;
            end
            FUNC_EOF: begin
                frame_now = (frame_now + 1) % FRAMES;
                free_slots = free_slots | pending_slots[frame_now];
                pending_slots[frame_now] = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    task automatic queue_request(input logic [FUNC_W-1:0] kind,
                                 input logic [SLOT_W-1:0] slot);
        request_t r;
        r.func = kind;
        r.slot = slot;
        request_q.push_back(r);
        words_queued++;
    endtask

    // block until every queued word is taken and every result is back
    task automatic wait_drained();
        do @(negedge aclk);
        while (words_taken != words_queued || awaited_results.size() != 0);
    endtask

    task automatic write_pool_size(input int unsigned value);
        int seen;
        wait_drained();
        repeat (4) @(negedge aclk);
        seen = cfg_writes;
        cfg_data <= CNT_W'(value);
        cfg_valid <= 1'b1;
        do @(negedge aclk);
        while (cfg_writes == seen);
        cfg_valid <= 1'b0;
    endtask

    // mostly allocate and free of slots likely held, some frame ends and noise
    task automatic random_requests(input int count, input int pool);
        int                eff;
        int                allocs;
        int                made;
        int                pick;
        logic [FUNC_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        eff = (pool > SLOTS) ? SLOTS : pool;
        allocs = 0;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            slot = SLOT_W'($urandom_range(0, SLOTS - 1));
            if (pick < 42) begin
                kind = FUNC_ALLOC;
                allocs++;
            end else if (pick < 80) begin
                kind = FUNC_FREE;
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    slot = SLOT_W'($urandom_range(0, (allocs < eff) ? allocs : eff - 1));
                end else if (pick < 9) begin
                    slot = SLOT_W'($urandom_range(0, eff - 1));
                end
            end else if (pick < 95) begin
                kind = FUNC_EOF;
            end else begin
                kind = FUNC_NONE;
            end
            queue_request(kind, slot);
            if (kind != FUNC_NONE) made++;
        end
    endtask

    // request driver
    always @(negedge aclk) begin : driver
        request_t next_req;
        if (aresetn && (!s_valid || s_took)) begin
            if (request_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_req = request_q.pop_front();
                s_valid <= 1'b1;
                s_func <= next_req.func;
                s_slot_index <= next_req.slot;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(negedge aclk) begin : receiver
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && !steady && results_seen >= 250) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && (steady || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: check results, predict accepted words, track config, watchdog
    always @(posedge aclk) begin : monitor
        slot_result_t want;
        logic         fired;
        fired = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                fired = 1'b1;
                results_seen++;
                if (awaited_results.size() == 0) begin
                    note_failure($sformatf("unexpected result word: granted %0d status %0d",
                                           m_granted_slot, m_status));
                end else begin
                    want = awaited_results.pop_front();
                    if (m_granted_slot !== want.granted || m_status !== want.status) begin
                        note_failure($sformatf(
                            "result %0d: granted exp %0d got %0d, status exp %0d got %0d",
                            results_seen, want.granted, m_granted_slot, want.status,
                            m_status));
                    end
                end
            end
            if (s_valid && s_ready) begin
                fired = 1'b1;
                want = apply_request(s_func, s_slot_index);
                if (s_func == FUNC_ALLOC && want.status == STAT_OK) grants++;
                if (want.status == STAT_NO_FREE) refusals++;
                if (want.status == STAT_BAD_FREE) bad_frees++;
                awaited_results.push_back(want);
                words_taken++;
            end
            if (cfg_valid && cfg_ready) begin
                fired = 1'b1;
                reset_pool(cfg_data);
                cfg_writes++;
            end
        end
        s_took <= aresetn && s_valid && s_ready;
        if (fired) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus
    initial begin
        reset_pool(SLOTS);
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // small pool so exhaustion, bad frees and frame recycling are all reached
        write_pool_size(8);
        repeat (8) queue_request(FUNC_ALLOC, '0);
        queue_request(FUNC_ALLOC, '1);
        queue_request(FUNC_FREE, 10'd0);
        queue_request(FUNC_FREE, 10'd0);
        queue_request(FUNC_FREE, 10'd8);
        queue_request(FUNC_FREE, 10'd1023);
        queue_request(FUNC_FREE, 10'd7);
        queue_request(FUNC_EOF, '1);
        queue_request(FUNC_ALLOC, '0);
        queue_request(FUNC_EOF, '0);
        queue_request(FUNC_EOF, '0);
        queue_request(FUNC_FREE, 10'd0);
        queue_request(FUNC_NONE, 10'd1023);
        queue_request(FUNC_ALLOC, '0);
        queue_request(FUNC_ALLOC, '0);
        queue_request(FUNC_ALLOC, '0);

        // random phases over several pool sizes, one of them without idling
        for (int p = 0; p < 7; p++) begin
            write_pool_size(pool_plan[p]);
            steady = (p == 5);
            random_requests(100, pool_plan[p]);
        end

        wait_drained();
        steady = 1'b0;
        repeat (DRAIN_WAIT) @(negedge aclk);
        while (awaited_results.size() != 0) begin
            void'(awaited_results.pop_front());
            note_failure("expected result never arrived");
        end

        $display("%0d request words, %0d pool settings, %0d results checked",
                 words_taken, cfg_writes, results_seen);
        $display("%0d grants, %0d pool-empty refusals, %0d rejected frees",
                 grants, refusals, bad_frees);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/dfsa_pkg.sv
src/dfsa_maps.sv
src/deferred_free_slot_allocator.sv
src/dfsa_checker.sv
test/tb_deferred_free_slot_allocator.sv
